@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/supa_pkg.sv @@
// Shared types and constants for the spectrum underlay block
package supa_pkg;
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_PEAK_HOLD = 2'd1;
    localparam logic [1:0] MODE_PEAK_BUF = 2'd2;
    localparam logic [1:0] MODE_AVERAGE = 2'd3;
    localparam logic [7:0] REG_MODE = 8'd0;
    localparam logic [7:0] REG_LENGTH = 8'd1;
    localparam logic [7:0] FILL_VALUE = 8'd1;
    localparam logic [7:0] DEFAULT_HISTORY = 8'd128;
endpackage

@@ sv/supa_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data
module supa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/supa_div.sv @@
// Restoring divider, one quotient bit per cycle
module supa_div #(
    parameter int NW = 20,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;

    // Shift in one numerator bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    // Hold divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0) || start;
    assign quo = quo_reg;
endmodule

@@ sv/spectrum_underlay_peak_average_top.sv @@
// Top level of the spectrum underlay: peak hold, peak over history, average
// One word in, one word out. After reset a clearing pass writes the peak store
// with ones before the first word is taken. Each bin word then passes from
// acceptance through a line-open step on the first bin of a line, the write,
// one history RAM read per held line through a single compare/add unit, a drain
// step and, in average mode, the serial divider, to the result register. A span
// change on the first bin of a line in peak-hold mode rewrites peak store and
// every held line with ones before that bin is handled. The output register
// frees the input side while a result waits.
`include "assert_macros.svh"
module spectrum_underlay_peak_average_top #(
    parameter int MAX_BINS = 1024,
    parameter int MAX_HISTORY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  magnitude,
    input  logic        span_changed,
    input  logic        line_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] underlay_value,
    output logic        line_done
);
    localparam int BW = $clog2(MAX_BINS);
    localparam int HW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int LW = $clog2(MAX_HISTORY + 1);
    localparam int SW = 12 + LW;
    localparam int AW = HW + BW;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_FILL, ST_OPEN, ST_WRITE, ST_SCAN,
        ST_DRAIN, ST_DIV, ST_DIVWAIT, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [1:0]      mode_reg;
    logic [7:0]      hlen_reg;
    logic [LW-1:0]   held_reg;
    logic [HW-1:0]   newest_reg;
    logic [BW-1:0]   bin_reg;
    logic [BW-1:0]   sweep_reg;
    logic [LW-1:0]   age_reg;
    logic [LW-1:0]   rcnt_reg;
    logic [7:0]      mag_reg;
    logic            last_reg;
    logic [7:0]      peak_reg;
    logic [7:0]      top_reg;
    logic [SW-1:0]   sum_reg;
    logic [11:0]     val_reg;
    logic            ov_reg, done_reg;
    logic            cfg_fire, in_fire;
    logic [LW-1:0]   len;
    logic [8:0]      hclip;

    // Ring length from the register
    always_comb
    begin
        hclip = (hlen_reg == 8'd0) ? 9'(supa_pkg::DEFAULT_HISTORY) : {1'b0, hlen_reg};
        if (hclip > 9'(MAX_HISTORY))
        begin
            hclip = 9'(MAX_HISTORY);
        end
        len = LW'(hclip);
    end

    // Memories: peak store and history lines
    logic          pk_we, hs_we;
    logic [BW-1:0] pk_addr;
    logic [7:0]    pk_wdata, pk_rdata, hs_wdata, hs_rdata;
    logic [AW-1:0] hs_waddr, hs_raddr;
    logic [HW-1:0] wslot;

    supa_ram #(.WIDTH(8), .DEPTH(MAX_BINS)) u_peak (
        .clk(clk), .we(pk_we), .waddr(pk_addr), .wdata(pk_wdata),
        .raddr(pk_addr), .rdata(pk_rdata)
    );
    supa_ram #(.WIDTH(8), .DEPTH(MAX_HISTORY * MAX_BINS)) u_hist (
        .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
        .raddr(hs_raddr), .rdata(hs_rdata)
    );

    // Divider for the average
    logic          div_start, div_busy;
    logic [SW-1:0] div_quo;
    supa_div #(.NW(SW), .DW(LW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_reg),
        .den(held_reg), .busy(div_busy), .quo(div_quo)
    );

    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire = in_valid && in_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready = (state_reg == ST_IDLE) && !cfg_valid;

    // Slot of the line at the current age; during the fill age k+1 is line k
    logic [LW:0]   slot_sum;
    logic [LW-1:0] age_sel;
    always_comb
    begin
        age_sel = (state_reg == ST_FILL) ? age_reg - 1'b1 : age_reg;
        slot_sum = {1'b0, LW'(newest_reg)} + {1'b0, len} - {1'b0, age_sel};
        if (slot_sum >= {1'b0, len})
        begin
            slot_sum = slot_sum - {1'b0, len};
        end
    end

    // Memory port control
    always_comb
    begin
        pk_we = 1'b0;
        pk_addr = bin_reg;
        pk_wdata = supa_pkg::FILL_VALUE;
        hs_we = 1'b0;
        wslot = newest_reg;
        hs_wdata = mag_reg;
        hs_raddr = {HW'(slot_sum), bin_reg};
        unique case (state_reg)
            ST_INIT:
            begin
                pk_we = 1'b1;
                pk_addr = sweep_reg;
            end
            ST_FILL:
            begin
                pk_addr = sweep_reg;
                wslot = HW'(slot_sum);
                pk_we = (age_reg == '0);
                hs_we = (age_reg != '0);
                hs_wdata = supa_pkg::FILL_VALUE;
            end
            ST_WRITE:
            begin
                hs_we = 1'b1;
                pk_we = (mode_reg == supa_pkg::MODE_PEAK_HOLD) && (mag_reg > pk_rdata);
                pk_wdata = mag_reg;
            end
            default:
            begin
            end
        endcase
        hs_waddr = {wslot, (state_reg == ST_FILL) ? sweep_reg : bin_reg};
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            mode_reg <= supa_pkg::MODE_NONE;
            hlen_reg <= supa_pkg::DEFAULT_HISTORY;
            held_reg <= '0;
            newest_reg <= '0;
            bin_reg <= '0;
            sweep_reg <= '0;
            age_reg <= '0;
            rcnt_reg <= '0;
            ov_reg <= 1'b0;
            div_start <= 1'b0;
        end
        else
        begin
            div_start <= (state_reg == ST_DIV);
            // Load the result register, or drop the word taken downstream
            if (state_reg == ST_OUT && (!ov_reg || out_ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == BW'(MAX_BINS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        if (cfg_index == supa_pkg::REG_MODE)
                        begin
                            mode_reg <= cfg_data[1:0];
                        end
                        else if (cfg_index == supa_pkg::REG_LENGTH && cfg_data != hlen_reg)
                        begin
                            hlen_reg <= cfg_data;
                            held_reg <= '0;
                            newest_reg <= '0;
                        end
                    end
                    else if (in_fire)
                    begin
                        if (bin_reg == '0 && span_changed
                            && mode_reg == supa_pkg::MODE_PEAK_HOLD)
                        begin
                            sweep_reg <= '0;
                            age_reg <= '0;
                            state_reg <= ST_FILL;
                        end
                        else if (bin_reg == '0)
                        begin
                            if (span_changed)
                            begin
                                held_reg <= '0;
                            end
                            state_reg <= ST_OPEN;
                        end
                        else
                        begin
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_FILL:
                begin
                    // age 0 is the peak store, age k+1 is held line k
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == BW'(MAX_BINS - 1))
                    begin
                        if (age_reg == held_reg)
                        begin
                            state_reg <= ST_OPEN;
                        end
                        else
                        begin
                            age_reg <= age_reg + 1'b1;
                        end
                    end
                end
                ST_OPEN:
                begin
                    if (held_reg == '0)
                    begin
                        newest_reg <= '0;
                        held_reg <= LW'(1);
                    end
                    else
                    begin
                        newest_reg <= (LW'(newest_reg) + 1'b1 >= len) ? '0 : newest_reg + 1'b1;
                        if (held_reg < len)
                        begin
                            held_reg <= held_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    age_reg <= '0;
                    rcnt_reg <= '0;
                    // an emptied history mid-line has nothing to scan
                    state_reg <= (held_reg == '0) ? ST_OUT : ST_SCAN;
                end
                ST_SCAN:
                begin
                    age_reg <= age_reg + 1'b1;
                    rcnt_reg <= rcnt_reg + 1'b1;
                    if (age_reg + 1'b1 == held_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    rcnt_reg <= rcnt_reg + 1'b1;
                    state_reg <= (mode_reg == supa_pkg::MODE_AVERAGE) ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIVWAIT;
                end
                ST_DIVWAIT:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                        bin_reg <= last_reg ? '0 : bin_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: shared compare/add over the history reads
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mag_reg <= magnitude;
            last_reg <= line_end;
        end
        if (state_reg == ST_WRITE)
        begin
            peak_reg <= (pk_we) ? mag_reg : pk_rdata;
            top_reg <= '0;
            sum_reg <= '0;
        end
        if ((state_reg == ST_SCAN && rcnt_reg != '0) || state_reg == ST_DRAIN)
        begin
            sum_reg <= sum_reg + SW'(hs_rdata);
            if (hs_rdata > top_reg)
            begin
                top_reg <= hs_rdata;
            end
        end
        if (state_reg == ST_OUT && (!ov_reg || out_ready))
        begin
            done_reg <= last_reg;
            unique case (mode_reg)
                supa_pkg::MODE_PEAK_HOLD: val_reg <= {peak_reg, 4'd0};
                supa_pkg::MODE_PEAK_BUF:  val_reg <= {top_reg, 4'd0};
                supa_pkg::MODE_AVERAGE:   val_reg <= (held_reg == '0) ? '0 : div_quo[11:0];
                default:                  val_reg <= '0;
            endcase
        end
        if (state_reg == ST_DIV)
        begin
            sum_reg <= {sum_reg[SW-5:0], 4'd0};
        end
    end

    assign out_valid = ov_reg;
    assign underlay_value = val_reg;
    assign line_done = done_reg;

    `ASSERT_IMPLY(a_held_le_len, clk, rst_n, state_reg == ST_IDLE, held_reg <= len)
    `ASSERT_IMPLY(a_no_in_busy, clk, rst_n, state_reg != ST_IDLE, !in_ready)
    `ASSERT_NEXT(a_out_set, clk, rst_n, state_reg == ST_OUT && !ov_reg, out_valid)
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the spectrum underlay peak/average block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS = 1024;
    localparam int HIST = 128;
    // bins written into a history slot the first time it is used
    localparam int LINE_W = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  magnitude;
    logic        span_changed;
    logic        line_end;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] underlay_value;
    logic        line_done;

    typedef struct packed {
        logic [11:0] value;
        logic        done;
    } underlay_word_t;

    // expected underlay words, oldest first
    underlay_word_t underlay_q[$];
    int unsigned    fail_count;
    int unsigned    burst_left;
    int unsigned    stall_style;

    // shadow of the block state
    logic [1:0] cur_mode;
    logic [7:0] cur_length;
    logic [7:0] peak_mem [0:BINS-1];
    logic [7:0] hist_mem [0:HIST-1][0:BINS-1];
    bit         slot_ready [0:HIST-1];
    int         held_lines;
    int         newest_slot;
    int         bin_pos;

    spectrum_underlay_peak_average_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .magnitude(magnitude), .span_changed(span_changed), .line_end(line_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .underlay_value(underlay_value), .line_done(line_done)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // effective number of history lines
    function automatic int ring_len();
        int h;
        h = int'(cur_length);
        if (h == 0 || h > HIST)
            h = HIST;
        return h;
    endfunction

    // slot that the next line will occupy
    function automatic int next_slot(input bit span);
        if ((span && cur_mode != supa_pkg::MODE_PEAK_HOLD) || held_lines == 0)
            return 0;
        return (newest_slot + 1) % ring_len();
    endfunction

    function automatic void open_line(input bit span);
        int len;
        int s;
        len = ring_len();
        if (span)
        begin
            if (cur_mode == supa_pkg::MODE_PEAK_HOLD)
            begin
                for (int i = 0; i < BINS; i++)
                    peak_mem[i] = supa_pkg::FILL_VALUE;
                for (int k = 0; k < held_lines; k++)
                begin
                    s = (newest_slot + len - (k % len)) % len;
                    for (int i = 0; i < BINS; i++)
                        hist_mem[s][i] = supa_pkg::FILL_VALUE;
                end
            end
            else
                held_lines = 0;
        end
        if (held_lines == 0)
        begin
            newest_slot = 0;
            held_lines = 1;
        end
        else
        begin
            newest_slot = (newest_slot + 1) % len;
            if (held_lines < len)
                held_lines++;
        end
    endfunction

    // compute the underlay word for one accepted bin
    function automatic underlay_word_t predict_underlay(input logic [7:0] mag,
                                                       input bit span, input bit last);
        underlay_word_t w;
        int b;
        int len;
        int s;
        int sum;
        int top;
        int e;
        b = bin_pos;
        if (b == 0)
            open_line(span);
        len = ring_len();
        hist_mem[newest_slot % HIST][b] = mag;
        if (b == LINE_W - 1)
            slot_ready[newest_slot % HIST] = 1'b1;
        if (cur_mode == supa_pkg::MODE_PEAK_HOLD && mag > peak_mem[b])
            peak_mem[b] = mag;
        sum = 0;
        top = 0;
        for (int k = 0; k < held_lines; k++)
        begin
            s = (newest_slot + len - (k % len)) % len;
            e = int'(hist_mem[s][b]);
            sum += e;
            if (e > top)
                top = e;
        end
        case (cur_mode)
            supa_pkg::MODE_PEAK_HOLD: w.value = 12'(int'(peak_mem[b]) << 4);
            supa_pkg::MODE_PEAK_BUF:  w.value = 12'(top << 4);
            supa_pkg::MODE_AVERAGE:
                w.value = (held_lines == 0) ? '0 : 12'((sum << 4) / held_lines);
            default:                  w.value = '0;
        endcase
        w.done = last;
        if (last)
            bin_pos = 0;
        else
            bin_pos = (b + 1) % BINS;
        return w;
    endfunction

    function automatic logic [7:0] rand_mag();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // send one bin word, with bursty gaps
    task automatic send_bin(input logic [7:0] mag, input bit span, input bit last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid     <= 1'b1;
        magnitude    <= mag;
        span_changed <= span;
        line_end     <= last;
        do
            @(posedge clk);
        while (!in_ready);
        underlay_q.push_back(predict_underlay(mag, span, last));
    endtask

    // send a line of n bins; a fresh history slot always gets at least LINE_W bins
    task automatic send_line(input int n, input bit span);
        if (!slot_ready[next_slot(span) % HIST] && n < LINE_W)
            n = LINE_W;
        for (int i = 0; i < n; i++)
            send_bin(rand_mag(), (i == 0) ? span : bit'($urandom_range(0, 1)), i == n - 1);
    endtask

    // hold until every expected word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (underlay_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == supa_pkg::REG_MODE)
            cur_mode = data[1:0];
        else if (idx == supa_pkg::REG_LENGTH && data != cur_length)
        begin
            cur_length  = data;
            held_lines  = 0;
            newest_slot = 0;
        end
    endtask

    // magnitude extremes with no mode set, span changes in every other mode, plus length corners
    task automatic test_directed();
        write_reg(supa_pkg::REG_LENGTH, 8'd3);
        send_bin(8'd0, 1'b0, 1'b0);
        send_bin(8'd255, 1'b1, 1'b0);
        send_bin(8'd17, 1'b0, 1'b0);
        send_bin(8'd128, 1'b0, 1'b1);
        write_reg(supa_pkg::REG_MODE, 8'(supa_pkg::MODE_PEAK_HOLD));
        send_line(4, 1'b0);
        send_line(4, 1'b0);
        send_line(2, 1'b1);
        write_reg(supa_pkg::REG_MODE, 8'(supa_pkg::MODE_PEAK_BUF));
        send_line(4, 1'b0);
        send_line(1, 1'b1);
        write_reg(supa_pkg::REG_MODE, 8'(supa_pkg::MODE_AVERAGE));
        send_line(3, 1'b0);
        send_line(4, 1'b1);
        write_reg(supa_pkg::REG_LENGTH, 8'd0);
        send_line(3, 1'b0);
        write_reg(supa_pkg::REG_LENGTH, 8'd0);
        send_line(2, 1'b0);
        write_reg(supa_pkg::REG_LENGTH, 8'd255);
        send_line(2, 1'b0);
    endtask

    // a line longer than the bin store wraps and reopens a line
    task automatic test_overlong_line();
        write_reg(supa_pkg::REG_LENGTH, 8'd1);
        write_reg(supa_pkg::REG_MODE, 8'(supa_pkg::MODE_PEAK_BUF));
        for (int i = 0; i < BINS + 2; i++)
            send_bin(rand_mag(), 1'b0, i == BINS + 1);
    endtask

    // random lines over a sweep of settings
    task automatic test_random();
        logic [7:0] lengths [6];
        logic [1:0] modes   [6];
        int lines;
        bit span;
        lengths = '{8'd128, 8'd1, 8'd2, 8'd0, 8'd200, 8'd7};
        modes   = '{supa_pkg::MODE_AVERAGE, supa_pkg::MODE_PEAK_HOLD,
                    supa_pkg::MODE_PEAK_BUF, supa_pkg::MODE_NONE,
                    supa_pkg::MODE_AVERAGE, supa_pkg::MODE_PEAK_HOLD};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(supa_pkg::REG_LENGTH, lengths[p]);
            write_reg(supa_pkg::REG_MODE, 8'(modes[p]));
            lines = (p == 0) ? 132 : 12;
            for (int l = 0; l < lines; l++)
            begin
                span = ($urandom_range(0, 5) == 0);
                // a span change in peak hold rewrites every held line: keep those cheap
                if (cur_mode == supa_pkg::MODE_PEAK_HOLD && held_lines > 8)
                    span = 1'b0;
                // lines stay within the bins every used slot has had written
                send_line($urandom_range(1, LINE_W), span);
            end
        end
    endtask

    // receiver stall pattern, style changes every so often
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_style <= 0;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                stall_style <= $urandom_range(0, 2);
            case (stall_style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // compare each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        underlay_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (underlay_q.size() == 0)
            begin
                $error("unexpected word: underlay_value %0d line_done %0d",
                       underlay_value, line_done);
                fail_count++;
            end
            else
            begin
                exp_w = underlay_q.pop_front();
                if (underlay_value !== exp_w.value)
                begin
                    $error("underlay_value: expected %0d, actual %0d",
                           exp_w.value, underlay_value);
                    fail_count++;
                end
                if (line_done !== exp_w.done)
                begin
                    $error("line_done: expected %0d, actual %0d", exp_w.done, line_done);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(64'd12 * 64'd3_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        magnitude    = '0;
        span_changed = 1'b0;
        line_end     = 1'b0;
        fail_count   = 0;
        burst_left   = 0;
        cur_mode     = supa_pkg::MODE_NONE;
        cur_length   = supa_pkg::DEFAULT_HISTORY;
        held_lines   = 0;
        newest_slot  = 0;
        bin_pos      = 0;
        for (int i = 0; i < BINS; i++)
            peak_mem[i] = supa_pkg::FILL_VALUE;
        for (int s = 0; s < HIST; s++)
        begin
            slot_ready[s] = 1'b0;
            for (int i = 0; i < BINS; i++)
                hist_mem[s][i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_overlong_line();
        test_random();
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && underlay_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ spectrum_underlay_peak_average_top.f @@
+incdir+sv
sv/supa_pkg.sv
sv/supa_ram.sv
sv/supa_div.sv
sv/spectrum_underlay_peak_average_top.sv
tb/tb_top.sv
